/* hdl/i2cm_pkg.sv */
// Shared types and constants for the tick-driven I2C master bit engine.
// No dependencies; every other file in hdl/ imports this package.
package i2cm_pkg;

    // Request codes carried on the input channel's tuser
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_TICKS_PER_US = 1'b0;
    localparam logic CFG_ACK_TIMEOUT  = 1'b1;

    localparam logic [7:0] TICKS_PER_US_RST = 8'd50;
    localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

    // Bits per byte transfer
    localparam logic [3:0] BYTE_BITS = 4'd8;

    localparam int DELAY_W = 11;
    localparam int RDATA_W = 16;

    // Bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_A    = 4'd1,
        PH_ST_B    = 4'd2,
        PH_SP_A    = 4'd3,
        PH_SP_B    = 4'd4,
        PH_SP_C    = 4'd5,
        PH_W_LOW   = 4'd6,
        PH_W_HIGH  = 4'd7,
        PH_WA_LOW  = 4'd8,
        PH_WA_HIGH = 4'd9,
        PH_WA_POLL = 4'd10,
        PH_R_LOW   = 4'd11,
        PH_R_HIGH  = 4'd12,
        PH_RA_LOW  = 4'd13,
        PH_RA_HIGH = 4'd14
    } phase_t;

    typedef struct packed {
        logic [7:0] ticks_per_us;
        logic [7:0] ack_timeout;
    } cfg_t;

    // One result item, packed lowest field last so tdata order is {fail, rx, ..., scl}
    typedef struct packed {
        logic       ack_failed;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive_enable;
        logic       sda_level;
        logic       scl_level;
    } result_t;

endpackage

/* hdl/i2cm_cfg.sv */
// Configuration registers (tick scale and ACK timeout) for the I2C bit engine.
// Depends on i2cm_pkg.
module i2cm_cfg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_data,
    output i2cm_pkg::cfg_t  cfg
);
    import i2cm_pkg::*;

    logic [7:0] tpu_reg;
    logic [7:0] timeout_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg     <= TICKS_PER_US_RST;
            timeout_reg <= ACK_TIMEOUT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TICKS_PER_US: tpu_reg     <= cfg_data;
                CFG_ACK_TIMEOUT:  timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.ticks_per_us = tpu_reg;
    assign cfg.ack_timeout  = timeout_reg;

endmodule

/* hdl/i2cm_core.sv */
// Bus sequencer: phase, delay counter, shifter, pin and status registers.
// Advances one tick per accepted request. Depends on i2cm_pkg.
module i2cm_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [2:0]          req_type,
    input  logic [7:0]          tx_byte,
    input  logic                send_ack,
    input  logic                sda_sample,
    input  i2cm_pkg::cfg_t      cfg,
    output i2cm_pkg::result_t   result
);
    import i2cm_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [3:0]           bit_idx_reg, bit_idx_next;
    logic [7:0]           shift_reg, shift_next;
    logic [7:0]           wait_reg, wait_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 drv_reg, drv_next;
    logic                 ack_choice_reg, ack_choice_next;
    logic [7:0]           rx_reg, rx_next;
    logic                 fail_reg, fail_next;
    logic                 done_next;

    logic [7:0]           unit;
    logic [DELAY_W-1:0]   u1, u4, u5;
    logic [DELAY_W-1:0]   delay_dec;
    logic                 advance;
    logic [7:0]           wait_base;
    logic [8:0]           wait_inc;
    logic                 poll_fail;

    // Delay unit lengths; a zero scale counts as one tick
    assign unit = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
    assign u1   = DELAY_W'(unit);
    assign u4   = DELAY_W'({unit, 2'b00});
    assign u5   = u4 + u1;

    // Timed segment countdown
    assign delay_dec = (delay_reg == '0) ? '0 : delay_reg - DELAY_W'(1);
    assign advance   = (phase_reg != PH_IDLE) && (phase_reg != PH_WA_POLL)
                       && (delay_dec == '0);

    // ACK poll: the count restarts on the tick that enters polling
    assign wait_base = (phase_reg == PH_WA_HIGH) ? 8'd0 : wait_reg;
    assign wait_inc  = {1'b0, wait_base} + 9'd1;
    assign poll_fail = wait_inc > {1'b0, cfg.ack_timeout};

    // Next phase, delay and done
    always_comb begin
        phase_next = phase_reg;
        delay_next = delay_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                case (req_type)
                    REQ_START: begin phase_next = PH_ST_A;  delay_next = u4; end
                    REQ_STOP:  begin phase_next = PH_SP_A;  delay_next = u4; end
                    REQ_WRITE: begin phase_next = PH_W_LOW; delay_next = u1; end
                    REQ_READ:  begin phase_next = PH_R_LOW; delay_next = u1; end
                    default: ;
                endcase
            end
            PH_WA_POLL: begin
                if (!sda_sample) begin
                    phase_next = PH_IDLE; delay_next = '0; done_next = 1'b1;
                end else if (poll_fail) begin
                    phase_next = PH_SP_A; delay_next = u4;
                end
            end
            default: begin
                delay_next = delay_dec;
                if (advance) begin
                    case (phase_reg)
                        PH_ST_A: begin phase_next = PH_ST_B; delay_next = u1; end
                        PH_SP_A: begin phase_next = PH_SP_B; delay_next = u1; end
                        PH_SP_B: begin phase_next = PH_SP_C; delay_next = u5; end
                        PH_W_LOW: begin phase_next = PH_W_HIGH; delay_next = u1; end
                        PH_W_HIGH: begin
                            phase_next = (bit_idx_reg < BYTE_BITS) ? PH_W_LOW : PH_WA_LOW;
                            delay_next = u1;
                        end
                        PH_WA_LOW: begin phase_next = PH_WA_HIGH; delay_next = u1; end
                        PH_WA_HIGH: begin
                            delay_next = '0;
                            if (!sda_sample) begin
                                phase_next = PH_IDLE; done_next = 1'b1;
                            end else if (poll_fail) begin
                                phase_next = PH_SP_A; delay_next = u4;
                            end else begin
                                phase_next = PH_WA_POLL;
                            end
                        end
                        PH_R_LOW: begin phase_next = PH_R_HIGH; delay_next = u1; end
                        PH_R_HIGH: begin
                            phase_next = (bit_idx_reg < BYTE_BITS) ? PH_R_LOW : PH_RA_LOW;
                            delay_next = u1;
                        end
                        PH_RA_LOW: begin phase_next = PH_RA_HIGH; delay_next = u1; end
                        default: begin
                            // end of start, stop and read-ack segments
                            phase_next = PH_IDLE; delay_next = '0; done_next = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    // Pins, shifter, counters and status
    always_comb begin
        bit_idx_next    = bit_idx_reg;
        shift_next      = shift_reg;
        wait_next       = wait_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        drv_next        = drv_reg;
        ack_choice_next = ack_choice_reg;
        rx_next         = rx_reg;
        fail_next       = fail_reg;
        case (phase_reg)
            PH_IDLE: begin
                case (req_type)
                    REQ_START: begin
                        drv_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
                    end
                    REQ_STOP: begin
                        drv_next = 1'b1; sda_next = 1'b0;
                    end
                    REQ_WRITE: begin
                        drv_next     = 1'b1;
                        scl_next     = 1'b0;
                        sda_next     = tx_byte[7];
                        shift_next   = {tx_byte[6:0], 1'b0};
                        bit_idx_next = 4'd1;
                    end
                    REQ_READ: begin
                        drv_next        = 1'b0;
                        scl_next        = 1'b0;
                        shift_next      = 8'd0;
                        bit_idx_next    = 4'd0;
                        ack_choice_next = send_ack;
                    end
                    default: ;
                endcase
            end
            PH_WA_POLL: begin
                if (!sda_sample) begin
                    scl_next = 1'b0; fail_next = 1'b0;
                end else if (poll_fail) begin
                    fail_next = 1'b1; drv_next = 1'b1; sda_next = 1'b0;
                end else begin
                    wait_next = wait_inc[7:0];
                end
            end
            default: begin
                if (advance) begin
                    case (phase_reg)
                        PH_ST_A:  sda_next = 1'b0;
                        PH_ST_B:  scl_next = 1'b0;
                        PH_SP_A:  scl_next = 1'b1;
                        PH_SP_B:  sda_next = 1'b1;
                        PH_W_LOW: scl_next = 1'b1;
                        PH_W_HIGH: begin
                            scl_next = 1'b0;
                            if (bit_idx_reg < BYTE_BITS) begin
                                sda_next     = shift_reg[7];
                                shift_next   = {shift_reg[6:0], 1'b0};
                                bit_idx_next = bit_idx_reg + 4'd1;
                            end else begin
                                drv_next = 1'b0; sda_next = 1'b1;
                            end
                        end
                        PH_WA_LOW: scl_next = 1'b1;
                        PH_WA_HIGH: begin
                            wait_next = 8'd0;
                            if (!sda_sample) begin
                                scl_next = 1'b0; fail_next = 1'b0;
                            end else if (poll_fail) begin
                                fail_next = 1'b1; drv_next = 1'b1; sda_next = 1'b0;
                            end else begin
                                wait_next = wait_inc[7:0];
                            end
                        end
                        PH_R_LOW: begin
                            scl_next     = 1'b1;
                            shift_next   = {shift_reg[6:0], sda_sample};
                            bit_idx_next = bit_idx_reg + 4'd1;
                        end
                        PH_R_HIGH: begin
                            scl_next = 1'b0;
                            if (!(bit_idx_reg < BYTE_BITS)) begin
                                drv_next = 1'b1; sda_next = !ack_choice_reg;
                            end
                        end
                        PH_RA_LOW: scl_next = 1'b1;
                        PH_RA_HIGH: begin
                            scl_next = 1'b0; rx_next = shift_reg;
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    end

    // State registers, updated once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            delay_reg      <= '0;
            bit_idx_reg    <= '0;
            shift_reg      <= '0;
            wait_reg       <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            drv_reg        <= 1'b1;
            ack_choice_reg <= 1'b0;
            rx_reg         <= '0;
            fail_reg       <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            delay_reg      <= delay_next;
            bit_idx_reg    <= bit_idx_next;
            shift_reg      <= shift_next;
            wait_reg       <= wait_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            drv_reg        <= drv_next;
            ack_choice_reg <= ack_choice_next;
            rx_reg         <= rx_next;
            fail_reg       <= fail_next;
        end
    end

    // Result shows the state after this tick
    assign result.scl_level        = scl_next;
    assign result.sda_level        = sda_next;
    assign result.sda_drive_enable = drv_next;
    assign result.busy_res         = (phase_next != PH_IDLE);
    assign result.done_res         = done_next;
    assign result.rx_byte          = rx_next;
    assign result.ack_failed       = fail_next;

endmodule

/* hdl/i2cm_out.sv */
// Result register for the I2C bit engine output channel.
// Holds one result until taken; a new one may load as the held one leaves. Depends on i2cm_pkg.
module i2cm_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  i2cm_pkg::result_t   result,
    output logic                space,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [i2cm_pkg::RDATA_W-1:0] m_tdata
);
    import i2cm_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Room when empty or when the held result leaves this cycle
    assign space = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = RDATA_W'(data_reg);

endmodule

/* hdl/i2c_master_bit_engine_unit.sv */
// Tick-driven I2C master bit engine. Each request on the input stream is one
// bus timing tick carrying the sampled SDA level and optionally a command
// (start, stop, write byte, read byte); each accepted request produces exactly
// one result showing the pin levels and status after that tick. One request can
// be taken every clock cycle while the result register has room: the next
// sequencer state is combinational and the result is registered, so it appears
// on the result stream the cycle after its request is accepted. A request is
// taken only while the result register is empty or its result leaves in the
// same cycle, so the request stream stalls while m_tready is low and a result waits.
// Top level; depends on i2cm_pkg, i2cm_cfg, i2cm_core and i2cm_out.
module i2c_master_bit_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] send_ack, [9] sda_sample, rest zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [i2cm_pkg::RDATA_W-1:0] m_tdata, // [0] scl_level, [1] sda_level,
                                   // [2] sda_drive_enable, [3] busy_res, [4] done_res,
                                   // [12:5] rx_byte, [13] ack_failed, rest zero
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import i2cm_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    space;
    logic    step;

    assign s_tready = space;
    assign step     = s_tvalid && space;

    i2cm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .req_type   (s_tuser),
        .tx_byte    (s_tdata[7:0]),
        .send_ack   (s_tdata[8]),
        .sda_sample (s_tdata[9]),
        .cfg        (cfg),
        .result     (result)
    );

    i2cm_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
